[sv/vtsc_pkg.sv]
// ----------------------------------------------------------------------------
// vtsc_pkg
// Shared widths, register indexes and beat types of the view transform and
// sphere cull unit.
// ----------------------------------------------------------------------------
package vtsc_pkg;

  localparam int COORD_WIDTH    = 20;
  localparam int AXIS_FRAC_BITS = 14;
  localparam int AXIS_WIDTH     = AXIS_FRAC_BITS + 2;
  localparam int TAN_WIDTH      = 16;
  localparam int TAN_FRAC       = 14;
  localparam int RADIUS_WIDTH   = COORD_WIDTH - 1;

  // datapath widths
  localparam int DIFF_W  = COORD_WIDTH + 1;             // world offset
  localparam int PROD_W  = DIFF_W + AXIS_WIDTH;         // offset times axis
  localparam int SUM_W   = PROD_W + 2;                  // three-term dot
  localparam int VIEW_W  = SUM_W - AXIS_FRAC_BITS;      // rounded view coord
  localparam int EXT_W   = VIEW_W + 1;                  // z + r and friends
  localparam int BOUND_W = EXT_W + TAN_WIDTH + 1;       // (z + r) * tan
  localparam int CMP_W   = BOUND_W + 1;                 // room for -bound
  localparam int BOX_W   = DIFF_W + 9;                  // 100 * (d -/+ r)

  localparam int BOX_SCALE = 100;
  localparam int BOX_LIMIT = 174;

  // configuration port
  localparam int DATA_W    = 64;
  localparam int IDX_W     = 3;
  localparam int ADDR_LSB  = 3;
  localparam int ADDR_W    = IDX_W + ADDR_LSB;

  localparam logic [AXIS_WIDTH-1:0]   AXIS_ONE       = AXIS_WIDTH'(1) << AXIS_FRAC_BITS;
  localparam logic [TAN_WIDTH-1:0]    TAN_RESET      = TAN_WIDTH'(1) << TAN_FRAC;
  localparam logic [RADIUS_WIDTH-1:0] MAX_DEPTH_RESET = RADIUS_WIDTH'(25600);

  typedef enum logic [IDX_W-1:0] {
    REG_CAM_ORIGIN = 3'd0,
    REG_AXIS_I     = 3'd1,
    REG_AXIS_J     = 3'd2,
    REG_AXIS_K     = 3'd3,
    REG_TAN_HALF_H = 3'd4,
    REG_TAN_HALF_V = 3'd5,
    REG_MAX_DEPTH  = 3'd6
  } reg_idx_t;

  // one camera axis: x component low, z high
  typedef logic [2:0][AXIS_WIDTH-1:0] axis_t;

  typedef struct packed {
    logic [2:0][COORD_WIDTH-1:0] cam_origin;
    axis_t [2:0]                 axis;        // 0: i, 1: j, 2: k
    logic [TAN_WIDTH-1:0]        tan_half_h;
    logic [TAN_WIDTH-1:0]        tan_half_v;
    logic [RADIUS_WIDTH-1:0]     max_depth;
  } cfg_t;

  typedef struct packed {
    logic                          func;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
    logic [RADIUS_WIDTH-1:0]       radius;
    logic                          last_item;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] view_x;
    logic signed [COORD_WIDTH-1:0] view_y;
    logic signed [COORD_WIDTH-1:0] view_z;
    logic                          visible;
    logic                          last_result;
  } out_item_t;

endpackage

[sv/vtsc_regs.sv]
// ----------------------------------------------------------------------------
// vtsc_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module vtsc_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vtsc_pkg::ADDR_W-1:0]   paddr,
  input  logic [vtsc_pkg::DATA_W-1:0]   pwdata,
  output logic [vtsc_pkg::DATA_W-1:0]   prdata,
  output vtsc_pkg::cfg_t                cfg
);

  vtsc_pkg::reg_idx_t idx;
  logic               wr_en;

  assign idx   = vtsc_pkg::reg_idx_t'(paddr[vtsc_pkg::ADDR_W-1:vtsc_pkg::ADDR_LSB]);
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cam_origin <= '0;
      // identity axes: unit on x, y, z respectively
      cfg.axis[0]    <= {{(2*vtsc_pkg::AXIS_WIDTH){1'b0}}, vtsc_pkg::AXIS_ONE};
      cfg.axis[1]    <= {{vtsc_pkg::AXIS_WIDTH{1'b0}}, vtsc_pkg::AXIS_ONE,
                         {vtsc_pkg::AXIS_WIDTH{1'b0}}};
      cfg.axis[2]    <= {vtsc_pkg::AXIS_ONE, {(2*vtsc_pkg::AXIS_WIDTH){1'b0}}};
      cfg.tan_half_h <= vtsc_pkg::TAN_RESET;
      cfg.tan_half_v <= vtsc_pkg::TAN_RESET;
      cfg.max_depth  <= vtsc_pkg::MAX_DEPTH_RESET;
    end else if (wr_en) begin
      unique case (idx)
        vtsc_pkg::REG_CAM_ORIGIN: begin
          cfg.cam_origin <= pwdata[3*vtsc_pkg::COORD_WIDTH-1:0];
        end
        vtsc_pkg::REG_AXIS_I: begin
          cfg.axis[0] <= pwdata[3*vtsc_pkg::AXIS_WIDTH-1:0];
        end
        vtsc_pkg::REG_AXIS_J: begin
          cfg.axis[1] <= pwdata[3*vtsc_pkg::AXIS_WIDTH-1:0];
        end
        vtsc_pkg::REG_AXIS_K: begin
          cfg.axis[2] <= pwdata[3*vtsc_pkg::AXIS_WIDTH-1:0];
        end
        vtsc_pkg::REG_TAN_HALF_H: begin
          cfg.tan_half_h <= pwdata[vtsc_pkg::TAN_WIDTH-1:0];
        end
        vtsc_pkg::REG_TAN_HALF_V: begin
          cfg.tan_half_v <= pwdata[vtsc_pkg::TAN_WIDTH-1:0];
        end
        vtsc_pkg::REG_MAX_DEPTH: begin
          cfg.max_depth <= pwdata[vtsc_pkg::RADIUS_WIDTH-1:0];
        end
        default: begin
          // drop writes past the last register
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      vtsc_pkg::REG_CAM_ORIGIN: prdata = vtsc_pkg::DATA_W'(cfg.cam_origin);
      vtsc_pkg::REG_AXIS_I:     prdata = vtsc_pkg::DATA_W'(cfg.axis[0]);
      vtsc_pkg::REG_AXIS_J:     prdata = vtsc_pkg::DATA_W'(cfg.axis[1]);
      vtsc_pkg::REG_AXIS_K:     prdata = vtsc_pkg::DATA_W'(cfg.axis[2]);
      vtsc_pkg::REG_TAN_HALF_H: prdata = vtsc_pkg::DATA_W'(cfg.tan_half_h);
      vtsc_pkg::REG_TAN_HALF_V: prdata = vtsc_pkg::DATA_W'(cfg.tan_half_v);
      vtsc_pkg::REG_MAX_DEPTH:  prdata = vtsc_pkg::DATA_W'(cfg.max_depth);
      default:                  prdata = '0;
    endcase
  end

endmodule

[sv/vtsc_pipe.sv]
// ----------------------------------------------------------------------------
// vtsc_pipe
// Five-stage transform and cull pipeline: offset, products and box test,
// dot sums, side bounds and depth test, side tests and saturation.
// ----------------------------------------------------------------------------
module vtsc_pipe (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  vtsc_pkg::in_item_t  item,
  input  vtsc_pkg::cfg_t      cfg,
  output logic                done,
  output vtsc_pkg::out_item_t result
);

  localparam int DW = vtsc_pkg::DIFF_W;
  localparam int PW = vtsc_pkg::PROD_W;
  localparam int SW = vtsc_pkg::SUM_W;
  localparam int VW = vtsc_pkg::VIEW_W;
  localparam int EW = vtsc_pkg::EXT_W;
  localparam int BW = vtsc_pkg::BOUND_W;
  localparam int CW = vtsc_pkg::CMP_W;
  localparam int XW = vtsc_pkg::BOX_W;
  localparam int RW = vtsc_pkg::RADIUS_WIDTH;
  localparam int OW = vtsc_pkg::COORD_WIDTH;

  localparam logic signed [XW-1:0] BOX_SCALE_S = XW'(vtsc_pkg::BOX_SCALE);
  localparam logic signed [XW-1:0] BOX_LIMIT_S = XW'(vtsc_pkg::BOX_LIMIT);
  localparam logic signed [SW-1:0] ROUND_HALF  = SW'(1) <<< (vtsc_pkg::AXIS_FRAC_BITS - 1);
  localparam logic signed [VW-1:0] OUT_MAX     = VW'((1 << (OW - 1)) - 1);
  localparam logic signed [VW-1:0] OUT_MIN     = -OUT_MAX - VW'(1);

  function automatic logic signed [OW-1:0] sat_coord(input logic signed [VW-1:0] v);
    logic signed [VW-1:0] c;
    c = v;
    if (v > OUT_MAX) c = OUT_MAX;
    if (v < OUT_MIN) c = OUT_MIN;
    return c[OW-1:0];
  endfunction

  // ---------------- stage 1: world offset ----------------
  logic signed [OW-1:0] pt  [3];
  logic signed [OW-1:0] org [3];

  logic                 s1_valid;
  logic signed [DW-1:0] s1_d [3];
  logic [RW-1:0]        s1_r;
  logic                 s1_sphere;
  logic                 s1_last;

  always_comb begin
    pt[0] = item.point_x;
    pt[1] = item.point_y;
    pt[2] = item.point_z;
    for (int a = 0; a < 3; a++) begin
      org[a] = $signed(cfg.cam_origin[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start;
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      s1_d[a] <= DW'(pt[a]) - DW'(org[a]);
    end
    s1_r      <= item.radius;
    s1_sphere <= item.func;
    s1_last   <= item.last_item;
  end

  // ---------------- stage 2: axis products, box test ----------------
  logic signed [XW-1:0] box_lim;
  logic signed [XW-1:0] box_dm [3];
  logic signed [XW-1:0] box_dp [3];
  logic                 box_ok;

  logic                 s2_valid;
  logic signed [PW-1:0] s2_prod [3][3];   // [axis][component]
  logic [RW-1:0]        s2_r;
  logic                 s2_sphere;
  logic                 s2_last;
  logic                 s2_box_ok;

  always_comb begin
    box_lim = XW'($signed({1'b0, cfg.max_depth})) * BOX_LIMIT_S;
    box_ok  = 1'b1;
    for (int a = 0; a < 3; a++) begin
      box_dm[a] = XW'(s1_d[a]) - XW'($signed({1'b0, s1_r}));
      box_dp[a] = XW'(s1_d[a]) + XW'($signed({1'b0, s1_r}));
      if (box_dm[a] * BOX_SCALE_S > box_lim) box_ok = 1'b0;
      if (box_dp[a] * BOX_SCALE_S < -box_lim) box_ok = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int x = 0; x < 3; x++) begin
      for (int a = 0; a < 3; a++) begin
        s2_prod[x][a] <= PW'(s1_d[a]) * PW'($signed(cfg.axis[x][a]));
      end
    end
    s2_r      <= s1_r;
    s2_sphere <= s1_sphere;
    s2_last   <= s1_last;
    s2_box_ok <= box_ok;
  end

  // ---------------- stage 3: dot sums, round half up ----------------
  logic signed [SW-1:0] dot_sum [3];

  logic                 s3_valid;
  logic signed [VW-1:0] s3_view [3];
  logic [RW-1:0]        s3_r;
  logic                 s3_sphere;
  logic                 s3_last;
  logic                 s3_box_ok;

  always_comb begin
    for (int x = 0; x < 3; x++) begin
      dot_sum[x] = SW'(s2_prod[x][0]) + SW'(s2_prod[x][1]) + SW'(s2_prod[x][2]) + ROUND_HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int x = 0; x < 3; x++) begin
      // floor by dropping the fraction bits
      s3_view[x] <= dot_sum[x][SW-1:vtsc_pkg::AXIS_FRAC_BITS];
    end
    s3_r      <= s2_r;
    s3_sphere <= s2_sphere;
    s3_last   <= s2_last;
    s3_box_ok <= s2_box_ok;
  end

  // ---------------- stage 4: side bounds, depth test ----------------
  logic signed [EW-1:0] far_ext;
  logic signed [EW-1:0] near_ext;
  logic                 depth_ok;

  logic                 s4_valid;
  logic signed [VW-1:0] s4_view [3];
  logic signed [BW-1:0] s4_bound_h;
  logic signed [BW-1:0] s4_bound_v;
  logic [RW-1:0]        s4_r;
  logic                 s4_sphere;
  logic                 s4_last;
  logic                 s4_box_ok;
  logic                 s4_depth_ok;

  always_comb begin
    far_ext  = EW'(s3_view[2]) + EW'($signed({1'b0, s3_r}));
    near_ext = EW'(s3_view[2]) - EW'($signed({1'b0, s3_r}));
    depth_ok = (near_ext < EW'($signed({1'b0, cfg.max_depth}))) && (far_ext > EW'(0));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    s4_view     <= s3_view;
    s4_bound_h  <= BW'(far_ext) * BW'($signed({1'b0, cfg.tan_half_h}));
    s4_bound_v  <= BW'(far_ext) * BW'($signed({1'b0, cfg.tan_half_v}));
    s4_r        <= s3_r;
    s4_sphere   <= s3_sphere;
    s4_last     <= s3_last;
    s4_box_ok   <= s3_box_ok;
    s4_depth_ok <= depth_ok;
  end

  // ---------------- stage 5: side tests, saturate, output ----------------
  logic signed [VW:0]   y_lo, y_hi, x_lo, x_hi;
  logic signed [CW-1:0] bnd_h, bnd_v;
  logic                 side_y_ok, side_x_ok;
  logic                 vis;

  always_comb begin
    y_lo  = (VW+1)'(s4_view[1]) - (VW+1)'($signed({1'b0, s4_r}));
    y_hi  = (VW+1)'(s4_view[1]) + (VW+1)'($signed({1'b0, s4_r}));
    x_lo  = (VW+1)'(s4_view[0]) - (VW+1)'($signed({1'b0, s4_r}));
    x_hi  = (VW+1)'(s4_view[0]) + (VW+1)'($signed({1'b0, s4_r}));
    bnd_h = CW'(s4_bound_h);
    bnd_v = CW'(s4_bound_v);
    side_y_ok = !((CW'(y_lo) <<< vtsc_pkg::TAN_FRAC) > bnd_h) &&
                !((CW'(y_hi) <<< vtsc_pkg::TAN_FRAC) < -bnd_h);
    side_x_ok = !((CW'(x_lo) <<< vtsc_pkg::TAN_FRAC) > bnd_v) &&
                !((CW'(x_hi) <<< vtsc_pkg::TAN_FRAC) < -bnd_v);
    vis = !s4_sphere || (s4_box_ok && s4_depth_ok && side_y_ok && side_x_ok);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    result.view_x      <= sat_coord(s4_view[0]);
    result.view_y      <= sat_coord(s4_view[1]);
    result.view_z      <= sat_coord(s4_view[2]);
    result.visible     <= vis;
    result.last_result <= s4_last;
  end

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##5 done)
    else $error("item did not reach the output after five cycles");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 5))
    else $error("result beat without a matching input beat");

  a_last_tag: assert property (@(posedge clk) disable iff (rst)
    start |-> ##5 (result.last_result == $past(item.last_item, 5)))
    else $error("end-of-list mark lost on its way through");

  a_vertex_visible: assert property (@(posedge clk) disable iff (rst)
    s4_valid && !s4_sphere |=> result.visible)
    else $error("vertex beat reported as culled");

  a_depth_cull: assert property (@(posedge clk) disable iff (rst)
    s4_valid && s4_sphere && !s4_depth_ok |=> !result.visible)
    else $error("sphere outside the depth range reported visible");
`endif

endmodule

[sv/view_transform_sphere_cull_unit.sv]
// ----------------------------------------------------------------------------
// view_transform_sphere_cull_unit
// World-to-view transform of points with bounding-sphere frustum culling.
// ----------------------------------------------------------------------------
// Takes one point or sphere per clock: busy never rises, so a start beat is
// taken on every cycle it is high. Each beat comes out on result with done
// high for one cycle, once it has passed the five pipeline register stages
// (offset, axis products, dot sums, tangent bound products, side tests and
// saturation); the axis and tangent multipliers set the clock. Results
// leave in input order and the receiver must take them as they come. Change
// the camera registers only while no beat is in the pipeline; a beat in
// flight sees the registers live.
module view_transform_sphere_cull_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  vtsc_pkg::in_item_t           item,
  output logic                         done,
  output vtsc_pkg::out_item_t          result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [vtsc_pkg::ADDR_W-1:0]  paddr,
  input  logic [vtsc_pkg::DATA_W-1:0]  pwdata,
  output logic [vtsc_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  vtsc_pkg::cfg_t cfg;

  // fully pipelined, nothing ever holds the input off
  assign busy   = 1'b0;
  assign pready = 1'b1;

  vtsc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  vtsc_pipe u_pipe (
    .clk    (clk),
    .rst    (rst),
    .start  (start && !busy),
    .item   (item),
    .cfg    (cfg),
    .done   (done),
    .result (result)
  );

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the view transform and sphere cull unit. A class
// keeps its own copy of the camera registers, works out view coordinates and
// the cull decision for every beat taken, and compares each done beat with
// the oldest one it predicted. Directed beats cover extremes, rounding ties,
// saturation and each cull test. Random phases follow, each under a freshly
// written camera, some with sender gaps in random bursts.
// ----------------------------------------------------------------------------

class view_cull_scoreboard;
  logic [3*vtsc_pkg::COORD_WIDTH-1:0] origin;
  logic [3*vtsc_pkg::AXIS_WIDTH-1:0]  axes [3];
  logic [vtsc_pkg::TAN_WIDTH-1:0]     tan_h;
  logic [vtsc_pkg::TAN_WIDTH-1:0]     tan_v;
  logic [vtsc_pkg::RADIUS_WIDTH-1:0]  depth_limit;
  vtsc_pkg::out_item_t                expected_q [$];
  int                                 mismatches;
  int                                 checked;
  int                                 spheres;
  int                                 visible_cnt;

  function new();
    origin      = '0;
    axes[0]     = (3*vtsc_pkg::AXIS_WIDTH)'(vtsc_pkg::AXIS_ONE);
    axes[1]     = (3*vtsc_pkg::AXIS_WIDTH)'(vtsc_pkg::AXIS_ONE) << vtsc_pkg::AXIS_WIDTH;
    axes[2]     = (3*vtsc_pkg::AXIS_WIDTH)'(vtsc_pkg::AXIS_ONE) << (2*vtsc_pkg::AXIS_WIDTH);
    tan_h       = vtsc_pkg::TAN_RESET;
    tan_v       = vtsc_pkg::TAN_RESET;
    depth_limit = vtsc_pkg::MAX_DEPTH_RESET;
    mismatches  = 0;
    checked     = 0;
    spheres     = 0;
    visible_cnt = 0;
  endfunction

  // drop bits above each register's width; unmapped indexes change nothing
  function void set_reg(int idx, logic [vtsc_pkg::DATA_W-1:0] v);
    case (idx)
      vtsc_pkg::REG_CAM_ORIGIN: origin = v[3*vtsc_pkg::COORD_WIDTH-1:0];
      vtsc_pkg::REG_AXIS_I:     axes[0] = v[3*vtsc_pkg::AXIS_WIDTH-1:0];
      vtsc_pkg::REG_AXIS_J:     axes[1] = v[3*vtsc_pkg::AXIS_WIDTH-1:0];
      vtsc_pkg::REG_AXIS_K:     axes[2] = v[3*vtsc_pkg::AXIS_WIDTH-1:0];
      vtsc_pkg::REG_TAN_HALF_H: tan_h = v[vtsc_pkg::TAN_WIDTH-1:0];
      vtsc_pkg::REG_TAN_HALF_V: tan_v = v[vtsc_pkg::TAN_WIDTH-1:0];
      vtsc_pkg::REG_MAX_DEPTH:  depth_limit = v[vtsc_pkg::RADIUS_WIDTH-1:0];
      default: ;
    endcase
  endfunction

  function logic [vtsc_pkg::DATA_W-1:0] reg_value(int idx);
    case (idx)
      vtsc_pkg::REG_CAM_ORIGIN: return vtsc_pkg::DATA_W'(origin);
      vtsc_pkg::REG_AXIS_I:     return vtsc_pkg::DATA_W'(axes[0]);
      vtsc_pkg::REG_AXIS_J:     return vtsc_pkg::DATA_W'(axes[1]);
      vtsc_pkg::REG_AXIS_K:     return vtsc_pkg::DATA_W'(axes[2]);
      vtsc_pkg::REG_TAN_HALF_H: return vtsc_pkg::DATA_W'(tan_h);
      vtsc_pkg::REG_TAN_HALF_V: return vtsc_pkg::DATA_W'(tan_v);
      vtsc_pkg::REG_MAX_DEPTH:  return vtsc_pkg::DATA_W'(depth_limit);
      default:                  return '0;
    endcase
  endfunction

  function logic signed [vtsc_pkg::COORD_WIDTH-1:0] clamp(longint x);
    longint hi;
    hi = (longint'(1) << (vtsc_pkg::COORD_WIDTH-1)) - 1;
    if (x > hi) x = hi;
    if (x < -hi - 1) x = -hi - 1;
    return x[vtsc_pkg::COORD_WIDTH-1:0];
  endfunction

  // scale both sides by 2^14 so the tangent needs no rounding
  function bit within_side(longint v, longint r, longint e, longint t);
    longint bound;
    bound = e * t;
    if ((v - r) * (longint'(1) << vtsc_pkg::TAN_FRAC) > bound) return 1'b0;
    if ((v + r) * (longint'(1) << vtsc_pkg::TAN_FRAC) < -bound) return 1'b0;
    return 1'b1;
  endfunction

  function vtsc_pkg::out_item_t view_and_cull(vtsc_pkg::in_item_t it);
    longint              p [3];
    longint              d [3];
    longint              v [3];
    longint              r;
    longint              lim;
    longint              sum;
    bit                  ok;
    vtsc_pkg::out_item_t o;
    p[0] = longint'($signed(it.point_x));
    p[1] = longint'($signed(it.point_y));
    p[2] = longint'($signed(it.point_z));
    for (int a = 0; a < 3; a++)
      d[a] = p[a] - longint'($signed(origin[a*vtsc_pkg::COORD_WIDTH +: vtsc_pkg::COORD_WIDTH]));
    for (int k = 0; k < 3; k++) begin
      sum = 0;
      for (int a = 0; a < 3; a++)
        sum += d[a] *
               longint'($signed(axes[k][a*vtsc_pkg::AXIS_WIDTH +: vtsc_pkg::AXIS_WIDTH]));
      // add half an LSB and floor: ties go up
      sum += longint'(1) << (vtsc_pkg::AXIS_FRAC_BITS - 1);
      v[k] = sum >>> vtsc_pkg::AXIS_FRAC_BITS;
    end
    ok = 1'b1;
    if (it.func) begin
      r   = longint'(it.radius);
      lim = vtsc_pkg::BOX_LIMIT * longint'(depth_limit);
      for (int a = 0; a < 3; a++) begin
        if (vtsc_pkg::BOX_SCALE * (d[a] - r) > lim) ok = 1'b0;
        if (vtsc_pkg::BOX_SCALE * (d[a] + r) < -lim) ok = 1'b0;
      end
      if (!within_side(v[1], r, v[2] + r, longint'(tan_h))) ok = 1'b0;
      if (!within_side(v[0], r, v[2] + r, longint'(tan_v))) ok = 1'b0;
      if (!((v[2] - r) < longint'(depth_limit) && (v[2] + r) > 0)) ok = 1'b0;
    end
    o.view_x      = clamp(v[0]);
    o.view_y      = clamp(v[1]);
    o.view_z      = clamp(v[2]);
    o.visible     = ok;
    o.last_result = it.last_item;
    return o;
  endfunction

  function void note_item(vtsc_pkg::in_item_t it);
    vtsc_pkg::out_item_t o;
    o = view_and_cull(it);
    if (it.func) begin
      spheres++;
      if (o.visible) visible_cnt++;
    end
    expected_q.push_back(o);
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function void check_result(vtsc_pkg::out_item_t got);
    vtsc_pkg::out_item_t want;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] result beat with nothing pending: %s%0d y=%0d z=%0d vis=%0b last=%0b",
                 $time, "x=", got.view_x, got.view_y, got.view_z, got.visible,
                 got.last_result);
      return;
    end
    want = expected_q.pop_front();
    checked++;
    if (got.view_x !== want.view_x || got.view_y !== want.view_y ||
        got.view_z !== want.view_z || got.visible !== want.visible ||
        got.last_result !== want.last_result) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("[%0t] beat %0d: expected x=%0d y=%0d z=%0d vis=%0b last=%0b",
                 $time, checked, want.view_x, want.view_y, want.view_z, want.visible,
                 want.last_result);
        $display("[%0t] beat %0d: got      x=%0d y=%0d z=%0d vis=%0b last=%0b",
                 $time, checked, got.view_x, got.view_y, got.view_z, got.visible,
                 got.last_result);
      end
    end
  endfunction

  function void check_readback(int idx, logic [vtsc_pkg::DATA_W-1:0] got);
    if (got !== reg_value(idx)) begin
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] register %0d read: expected %h, got %h", $time, idx,
                 reg_value(idx), got);
    end
  endfunction
endclass

module tb_top;

  localparam int CYCLE_LIMIT      = 200000;
  localparam int RANDOM_PHASES    = 9;
  localparam int BEATS_PER_PHASE  = 130;
  localparam int UNMAPPED_IDX     = 7;
  localparam int TAIL_CYCLES      = 12;
  localparam int UNIT             = 1 << vtsc_pkg::AXIS_FRAC_BITS;
  localparam int DIAG             = 11585;   // cos 45 in Q2.14
  localparam int CW               = vtsc_pkg::COORD_WIDTH;
  localparam int AW               = vtsc_pkg::AXIS_WIDTH;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic                          busy;
  vtsc_pkg::in_item_t            item = '0;
  logic                          done;
  vtsc_pkg::out_item_t           result;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [vtsc_pkg::ADDR_W-1:0]   paddr = '0;
  logic [vtsc_pkg::DATA_W-1:0]   pwdata = '0;
  logic [vtsc_pkg::DATA_W-1:0]   prdata;
  logic                          pready;

  view_cull_scoreboard sb;
  int                  cycles = 0;
  int                  settings_run = 0;

  view_transform_sphere_cull_unit dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .item    (item),
    .done    (done),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result);
  end

  function automatic int rs(int m);
    return int'($urandom_range(2*m)) - m;
  endfunction

  function automatic logic [3*AW-1:0] axis3(int x, int y, int z);
    return {AW'(z), AW'(y), AW'(x)};
  endfunction

  function automatic logic [3*CW-1:0] origin3(int x, int y, int z);
    return {CW'(z), CW'(y), CW'(x)};
  endfunction

  function automatic vtsc_pkg::in_item_t beat(bit f, int x, int y, int z, int r, bit last);
    vtsc_pkg::in_item_t b;
    b.func      = f;
    b.point_x   = CW'(x);
    b.point_y   = CW'(y);
    b.point_z   = CW'(z);
    b.radius    = vtsc_pkg::RADIUS_WIDTH'(r);
    b.last_item = last;
    return b;
  endfunction

  // mostly spheres near the camera, scaled to the far limit so all tests bite
  function automatic vtsc_pkg::in_item_t make_beat();
    logic [95:0] raw;
    int          s;
    int          md;
    if ($urandom_range(99) < 30) begin
      raw = {$urandom, $urandom, $urandom};
      return raw[$bits(vtsc_pkg::in_item_t)-1:0];
    end
    md = int'(sb.depth_limit);
    case ($urandom_range(4))
      0: s = 256;
      1: s = 4096;
      2: s = md / 2 + 1;
      3: s = md + 1;
      default: s = 1 << 18;
    endcase
    return beat($urandom_range(9) < 8,
                int'($signed(sb.origin[0 +: CW])) + rs(s),
                int'($signed(sb.origin[CW +: CW])) + rs(s),
                int'($signed(sb.origin[2*CW +: CW])) + rs(s),
                $urandom_range(s), $urandom_range(7) == 0);
  endfunction

  task automatic send_beat(vtsc_pkg::in_item_t it);
    @(negedge clk);
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    sb.note_item(it);
  endtask

  task automatic hold_off(int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // drop start and let the pipeline drain
  task automatic quiesce();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic reg_write(int idx, logic [vtsc_pkg::DATA_W-1:0] v);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= vtsc_pkg::ADDR_W'(idx << vtsc_pkg::ADDR_LSB);
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, v);
  endtask

  task automatic reg_read_check(int idx);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= vtsc_pkg::ADDR_W'(idx << vtsc_pkg::ADDR_LSB);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.check_readback(idx, prdata);
  endtask

  // write every register with junk above its width, poke the unmapped slot,
  // then read every mapped register back
  task automatic program_all(logic [3*CW-1:0] org, logic [3*AW-1:0] ai,
                             logic [3*AW-1:0] aj, logic [3*AW-1:0] ak,
                             logic [vtsc_pkg::TAN_WIDTH-1:0] th,
                             logic [vtsc_pkg::TAN_WIDTH-1:0] tv,
                             logic [vtsc_pkg::RADIUS_WIDTH-1:0] md);
    logic [vtsc_pkg::DATA_W-1:0] junk;
    junk = {$urandom, $urandom};
    reg_write(vtsc_pkg::REG_CAM_ORIGIN, vtsc_pkg::DATA_W'(org) | (junk << (3*CW)));
    reg_write(vtsc_pkg::REG_AXIS_I, vtsc_pkg::DATA_W'(ai) | (junk << (3*AW)));
    reg_write(vtsc_pkg::REG_AXIS_J, vtsc_pkg::DATA_W'(aj) | (junk << (3*AW)));
    reg_write(vtsc_pkg::REG_AXIS_K, vtsc_pkg::DATA_W'(ak) | (junk << (3*AW)));
    reg_write(vtsc_pkg::REG_TAN_HALF_H,
              vtsc_pkg::DATA_W'(th) | (junk << vtsc_pkg::TAN_WIDTH));
    reg_write(vtsc_pkg::REG_TAN_HALF_V,
              vtsc_pkg::DATA_W'(tv) | (junk << vtsc_pkg::TAN_WIDTH));
    reg_write(vtsc_pkg::REG_MAX_DEPTH,
              vtsc_pkg::DATA_W'(md) | (junk << vtsc_pkg::RADIUS_WIDTH));
    reg_write(UNMAPPED_IDX, {$urandom, $urandom});
    for (int i = vtsc_pkg::REG_CAM_ORIGIN; i <= vtsc_pkg::REG_MAX_DEPTH; i++)
      reg_read_check(i);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    settings_run++;
  endtask

  function automatic logic [vtsc_pkg::TAN_WIDTH-1:0] pick_tan();
    case ($urandom_range(4))
      0: return '0;
      1: return vtsc_pkg::TAN_RESET;
      2: return '1;
      3: return vtsc_pkg::TAN_WIDTH'($urandom);
      default: return vtsc_pkg::TAN_WIDTH'($urandom_range(4096, 32768));
    endcase
  endfunction

  function automatic logic [vtsc_pkg::RADIUS_WIDTH-1:0] pick_depth();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return vtsc_pkg::RADIUS_WIDTH'($urandom);
      3: return vtsc_pkg::RADIUS_WIDTH'($urandom_range(256, 65536));
      default: return vtsc_pkg::MAX_DEPTH_RESET;
    endcase
  endfunction

  task automatic random_camera();
    logic [3*AW-1:0] ax [3];
    logic [3*CW-1:0] org;
    int              perm [3];
    int              c [3];
    int              j;
    int              tmp;
    case ($urandom_range(3))
      0: begin
        // axis-aligned camera: permuted, signed unit axes
        perm = '{0, 1, 2};
        for (int i = 2; i > 0; i--) begin
          j = $urandom_range(i);
          tmp = perm[i];
          perm[i] = perm[j];
          perm[j] = tmp;
        end
        for (int row = 0; row < 3; row++) begin
          c = '{0, 0, 0};
          c[perm[row]] = $urandom_range(1) ? -UNIT : UNIT;
          ax[row] = axis3(c[0], c[1], c[2]);
        end
      end
      1: begin
        ax[0] = axis3(DIAG, DIAG, 0);
        ax[1] = axis3(-DIAG, DIAG, 0);
        ax[2] = axis3(0, 0, UNIT);
      end
      2: begin
        for (int row = 0; row < 3; row++) ax[row] = axis3(rs(UNIT), rs(UNIT), rs(UNIT));
      end
      default: begin
        for (int row = 0; row < 3; row++) ax[row] = (3*AW)'({$urandom, $urandom});
      end
    endcase
    if ($urandom_range(1)) org = origin3(rs(65536), rs(65536), rs(65536));
    else org = (3*CW)'({$urandom, $urandom});
    program_all(org, ax[0], ax[1], ax[2], pick_tan(), pick_tan(), pick_depth());
  endtask

  initial begin
    int idle_pct;
    sb = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset camera: identity axes, unit tangents, far limit 25600
    send_beat(beat(0, 0, 0, 0, 0, 1));
    send_beat(beat(0, 524287, 524287, 524287, 524287, 0));
    send_beat(beat(0, -524288, -524288, -524288, 0, 1));
    send_beat(beat(1, 0, 0, 12800, 256, 0));
    send_beat(beat(1, 0, 0, -2560, 256, 0));        // behind the camera
    send_beat(beat(1, 0, 0, 30000, 0, 0));          // past the far limit
    send_beat(beat(1, 0, 0, 25700, 200, 1));        // straddles the far limit
    send_beat(beat(1, 0, 20000, 5120, 0, 0));       // outside the y side
    send_beat(beat(1, -20000, 0, 5120, 0, 0));      // outside the x side
    send_beat(beat(1, 0, 5120, 5120, 0, 0));        // exactly on the side plane
    send_beat(beat(1, 0, 0, 0, 0, 0));              // zero depth interval
    send_beat(beat(1, 0, 0, 0, 524287, 1));
    send_beat(beat(1, 524287, 524287, 524287, 524287, 0));
    send_beat(beat(1, -524288, -524288, -524288, 0, 1));
    send_beat(beat(1, 100000, 0, 12800, 50000, 0)); // outside the world box
    quiesce();

    // half axes give rounding ties, near-2.0 axes saturate, zero y tangent
    program_all('0, axis3(8192, 0, 0), axis3(0, -8192, 0), axis3(32767, 32767, 32767),
                '0, '1, '1);
    send_beat(beat(0, 1, 1, 0, 0, 0));
    send_beat(beat(0, -1, -1, 0, 0, 0));
    send_beat(beat(0, 3, -3, 0, 0, 0));
    send_beat(beat(0, 524287, 524287, 524287, 0, 0));
    send_beat(beat(1, -524288, -524288, -524288, 100, 1));
    send_beat(beat(1, 0, 0, 2560, 0, 0));
    quiesce();

    // all registers zero: even with a zero far limit a sphere around the camera stays visible
    program_all('0, '0, '0, '0, '0, '0, '0);
    send_beat(beat(1, 0, 0, 0, 524287, 0));
    send_beat(beat(0, 100, 200, 300, 5, 1));
    quiesce();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == 0)
        program_all('1, '1, '1, '1, '1, '1, '1);
      else if (ph == 1)
        program_all('0, axis3(UNIT, 0, 0), axis3(0, UNIT, 0), axis3(0, 0, UNIT),
                    vtsc_pkg::TAN_RESET, vtsc_pkg::TAN_RESET, vtsc_pkg::MAX_DEPTH_RESET);
      else
        random_camera();
      case ($urandom_range(2))
        0: idle_pct = 0;
        1: idle_pct = 8;
        default: idle_pct = 25;
      endcase
      // closing phase runs back to back
      if (ph == RANDOM_PHASES - 1) idle_pct = 0;
      for (int n = 0; n < BEATS_PER_PHASE; n++) begin
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) hold_off($urandom_range(1, 6));
        send_beat(make_beat());
      end
      quiesce();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Checked %0d result beats: %0d spheres (%0d visible), rest vertices,",
             sb.checked, sb.spheres, sb.visible_cnt);
    $display("under %0d camera settings; %0d mismatches, %0d beats still pending.",
             settings_run, sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

[files.f]
sv/vtsc_pkg.sv
sv/vtsc_regs.sv
sv/vtsc_pipe.sv
sv/view_transform_sphere_cull_unit.sv
dv/tb_top.sv
